### sv/clvmt_pkg.sv
// Shared types, field layout and command codes of the client level vote table.
package clvmt_pkg;

    localparam int MAX_CLIENTS_DEF = 16;
    localparam int LEVEL_BITS_DEF  = 16;

    // Field widths of one beat on either side.
    localparam int CMD_W   = 3;
    localparam int KEY_W   = 16;
    localparam int LEVEL_W = 16;
    localparam int COUNT_W = 5;

    // Input tdata layout, lowest bit first.
    localparam int IN_CMD_LO = 0;
    localparam int IN_ID_LO  = IN_CMD_LO + CMD_W;
    localparam int IN_LVL_LO = IN_ID_LO + KEY_W;
    localparam int IN_BITS   = IN_LVL_LO + LEVEL_W;
    localparam int IN_W      = ((IN_BITS + 7) / 8) * 8;

    // Output tdata layout, lowest bit first.
    localparam int OUT_OK_LO  = 0;
    localparam int OUT_RD_LO  = OUT_OK_LO + 1;
    localparam int OUT_MAX_LO = OUT_RD_LO + LEVEL_W;
    localparam int OUT_CNT_LO = OUT_MAX_LO + LEVEL_W;
    localparam int OUT_BITS   = OUT_CNT_LO + COUNT_W;
    localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [CMD_W-1:0] CMD_SET    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_GET    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLIP   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_APPLY
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;   // capture the input beat and reset the scan
        logic issue;   // read the next table entry
        logic finish;  // commit the command and load the result register
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_scan;  // the offered command must walk the table
        logic scan_last;  // the read being issued is the last entry
        logic out_space;  // the result register can take a new beat
    } t_dp_status;

endpackage

### sv/clvmt_ctrl.sv
// Controller state machine that sequences the table walk and the commit.
module clvmt_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  clvmt_pkg::t_dp_status  i_status,
    output logic                   o_in_ready,
    output clvmt_pkg::t_ctrl_cmd   o_cmd
);

    clvmt_pkg::t_state r_state;
    clvmt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= clvmt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            clvmt_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_status.need_scan ? clvmt_pkg::ST_SCAN : clvmt_pkg::ST_APPLY;
                end
            end
            clvmt_pkg::ST_SCAN: begin
                if (i_status.scan_last) begin
                    n_state = clvmt_pkg::ST_DRAIN;
                end
            end
            clvmt_pkg::ST_DRAIN: begin
                n_state = clvmt_pkg::ST_APPLY;
            end
            clvmt_pkg::ST_APPLY: begin
                if (i_status.out_space) begin
                    n_state = clvmt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = clvmt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready   = 1'b0;
        o_cmd.start  = 1'b0;
        o_cmd.issue  = 1'b0;
        o_cmd.finish = 1'b0;
        case (r_state)
            clvmt_pkg::ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.start = i_in_valid;
            end
            clvmt_pkg::ST_SCAN: begin
                o_cmd.issue = 1'b1;
            end
            clvmt_pkg::ST_DRAIN: begin
            end
            clvmt_pkg::ST_APPLY: begin
                o_cmd.finish = i_status.out_space;
            end
            default: begin
            end
        endcase
    end

endmodule

### sv/clvmt_dp.sv
// Datapath: key and level memories, valid bits, scan compare and commit logic.
module clvmt_dp #(
    parameter int MAX_CLIENTS = clvmt_pkg::MAX_CLIENTS_DEF,
    parameter int LEVEL_BITS  = clvmt_pkg::LEVEL_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  clvmt_pkg::t_ctrl_cmd         i_cmd,
    output clvmt_pkg::t_dp_status        o_status,
    input  logic [clvmt_pkg::IN_W-1:0]   i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [clvmt_pkg::OUT_W-1:0]  o_out_data
);

    localparam int IW = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
    localparam int CW = $clog2(MAX_CLIENTS + 1);
    localparam int LW = (LEVEL_BITS < clvmt_pkg::LEVEL_W) ? LEVEL_BITS : clvmt_pkg::LEVEL_W;
    localparam int LAST_IDX = MAX_CLIENTS - 1;

    logic [clvmt_pkg::KEY_W-1:0] mem_key [MAX_CLIENTS];
    logic [LW-1:0]               mem_lvl [MAX_CLIENTS];

    logic [clvmt_pkg::CMD_W-1:0] r_cmd;
    logic [clvmt_pkg::KEY_W-1:0] r_id;
    logic [LW-1:0]               r_lvl;
    logic [MAX_CLIENTS-1:0]      r_valid;
    logic [CW-1:0]               r_count;
    logic [LW-1:0]               r_max;
    logic [IW-1:0]               r_rd_idx;
    logic [IW-1:0]               r_cmp_idx;
    logic                        r_pipe_vld;
    logic [clvmt_pkg::KEY_W-1:0] r_rd_key;
    logic [LW-1:0]               r_rd_lvl;
    logic                        r_found;
    logic [IW-1:0]               r_slot;
    logic [LW-1:0]               r_found_lvl;
    logic                        r_free_found;
    logic [IW-1:0]               r_free_slot;
    logic [LW-1:0]               r_omax;
    logic                        r_out_vld;
    logic [clvmt_pkg::OUT_W-1:0] r_out_data;

    logic [clvmt_pkg::CMD_W-1:0] in_cmd;
    logic [clvmt_pkg::KEY_W-1:0] in_id;
    logic [LW-1:0]               in_lvl;

    logic cmp_valid;
    logic cmp_hit;
    logic clip_wr;

    logic          a_ok;
    logic [LW-1:0] a_rd;
    logic [LW-1:0] a_max;
    logic [IW-1:0] a_slot;
    logic          a_key_we;
    logic          a_lvl_we;
    logic          a_set_vld;
    logic          a_clr_vld;
    logic          a_clear_all;
    logic [CW-1:0] n_count;
    logic          id_ok;
    logic [LW-1:0] set_max;

    logic                        lvl_we;
    logic [IW-1:0]               lvl_waddr;
    logic [clvmt_pkg::OUT_W-1:0] n_out_data;

    assign in_cmd = i_in_data[clvmt_pkg::IN_CMD_LO +: clvmt_pkg::CMD_W];
    assign in_id  = i_in_data[clvmt_pkg::IN_ID_LO +: clvmt_pkg::KEY_W];
    assign in_lvl = LW'(i_in_data[clvmt_pkg::IN_LVL_LO +: clvmt_pkg::LEVEL_W]);

    assign o_status.need_scan = (in_cmd == clvmt_pkg::CMD_CLIP)
        || ((in_cmd == clvmt_pkg::CMD_SET || in_cmd == clvmt_pkg::CMD_GET
             || in_cmd == clvmt_pkg::CMD_REMOVE) && in_id != '0);
    assign o_status.scan_last = (r_rd_idx == IW'(LAST_IDX));
    assign o_status.out_space = !r_out_vld || i_out_ready;

    // Compare stage works on the entry whose registered read just returned.
    assign cmp_valid = r_pipe_vld && r_valid[r_cmp_idx];
    assign cmp_hit   = cmp_valid && (r_rd_key == r_id);
    assign clip_wr   = cmp_valid && (r_cmd == clvmt_pkg::CMD_CLIP) && (r_rd_lvl > r_lvl);

    assign id_ok   = (r_id != '0);
    assign set_max = (r_omax > r_lvl) ? r_omax : r_lvl;

    // Commit. The walk gathered the matching slot, the lowest free slot and
    // the maximum over every other valid entry, so the new maximum needs no
    // second walk.
    always_comb begin
        a_ok        = 1'b0;
        a_rd        = '0;
        a_max       = r_max;
        a_slot      = r_slot;
        a_key_we    = 1'b0;
        a_lvl_we    = 1'b0;
        a_set_vld   = 1'b0;
        a_clr_vld   = 1'b0;
        a_clear_all = 1'b0;
        case (r_cmd)
            clvmt_pkg::CMD_SET: begin
                if (id_ok) begin
                    if (r_lvl == '0) begin
                        a_ok      = 1'b1;
                        a_clr_vld = r_found;
                        a_max     = r_omax;
                    end else if (r_found) begin
                        a_ok     = 1'b1;
                        a_lvl_we = 1'b1;
                        a_max    = set_max;
                    end else if (r_free_found) begin
                        a_ok      = 1'b1;
                        a_slot    = r_free_slot;
                        a_key_we  = 1'b1;
                        a_lvl_we  = 1'b1;
                        a_set_vld = 1'b1;
                        a_max     = set_max;
                    end
                end
            end
            clvmt_pkg::CMD_GET: begin
                if (id_ok && r_found) begin
                    a_ok = 1'b1;
                    a_rd = r_found_lvl;
                end
            end
            clvmt_pkg::CMD_REMOVE: begin
                if (id_ok && r_found) begin
                    a_ok      = 1'b1;
                    a_clr_vld = 1'b1;
                    a_max     = r_omax;
                end
            end
            clvmt_pkg::CMD_CLIP: begin
                a_ok  = 1'b1;
                a_max = (r_max > r_lvl) ? r_lvl : r_max;
            end
            clvmt_pkg::CMD_CLEAR: begin
                a_ok        = 1'b1;
                a_clear_all = 1'b1;
                a_max       = '0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (a_clear_all) begin
            n_count = '0;
        end else if (a_set_vld) begin
            n_count = r_count + CW'(1);
        end else if (a_clr_vld) begin
            n_count = r_count - CW'(1);
        end
    end

    always_comb begin
        n_out_data = '0;
        n_out_data[clvmt_pkg::OUT_OK_LO]                            = a_ok;
        n_out_data[clvmt_pkg::OUT_RD_LO +: clvmt_pkg::LEVEL_W]  = clvmt_pkg::LEVEL_W'(a_rd);
        n_out_data[clvmt_pkg::OUT_MAX_LO +: clvmt_pkg::LEVEL_W] = clvmt_pkg::LEVEL_W'(a_max);
        n_out_data[clvmt_pkg::OUT_CNT_LO +: clvmt_pkg::COUNT_W] = clvmt_pkg::COUNT_W'(n_count);
    end

    // Clip writes during the walk; set writes at commit. Both write the cap
    // or the new level, which is the captured level either way.
    assign lvl_we    = clip_wr || (i_cmd.finish && a_lvl_we);
    assign lvl_waddr = clip_wr ? r_cmp_idx : a_slot;

    always_ff @(posedge i_clk) begin
        r_rd_key <= mem_key[r_rd_idx];
        r_rd_lvl <= mem_lvl[r_rd_idx];
        if (lvl_we) begin
            mem_lvl[lvl_waddr] <= r_lvl;
        end
        if (i_cmd.finish && a_key_we) begin
            mem_key[a_slot] <= r_id;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_count    <= '0;
            r_max      <= '0;
            r_pipe_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_pipe_vld <= i_cmd.issue;
            if (i_cmd.finish) begin
                r_count <= n_count;
                r_max   <= a_max;
                if (a_clear_all) begin
                    r_valid <= '0;
                end else if (a_set_vld) begin
                    r_valid[a_slot] <= 1'b1;
                end else if (a_clr_vld) begin
                    r_valid[a_slot] <= 1'b0;
                end
            end
            if (i_cmd.finish) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Captured command and scan results.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_cmd        <= in_cmd;
            r_id         <= in_id;
            r_lvl        <= in_lvl;
            r_rd_idx     <= '0;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
            r_omax       <= '0;
        end else begin
            if (i_cmd.issue) begin
                r_cmp_idx <= r_rd_idx;
                r_rd_idx  <= r_rd_idx + IW'(1);
            end
            if (cmp_hit) begin
                r_found     <= 1'b1;
                r_slot      <= r_cmp_idx;
                r_found_lvl <= r_rd_lvl;
            end else if (cmp_valid && r_rd_lvl > r_omax) begin
                r_omax <= r_rd_lvl;
            end
            if (r_pipe_vld && !r_valid[r_cmp_idx] && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_slot  <= r_cmp_idx;
            end
        end
        if (i_cmd.finish) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;

endmodule

### sv/client_level_vote_max_table_top.sv
// Top level of the client level vote table with its running maximum.
//
// This block keeps up to MAX_CLIENTS client entries, each a 16-bit client id
// and a requested level, and reports the maximum level over all entries after
// every command. Each input beat carries one command (set, get, remove, clip
// to a cap, or clear) and produces exactly one output beat with a success
// flag, the level read by a get, the maximum level and the entry count.
// Client id zero is never stored, and a set of a new id into a full table
// fails without change. Set, get and remove with a nonzero id, and clip, walk
// the key and level memories one entry per clock. The controller captures the
// beat, issues one read per entry, waits in a drain state for the last
// registered read, and then commits. Clear, undefined commands, and set, get
// and remove with client id zero skip the walk and go from capture straight
// to the commit. The result sits in an output register, so the next beat is
// accepted while a result still waits; a commit waits only if the previous
// result has not been taken yet. The entry count field is five bits wide and
// shows the count modulo 32. The valid bits clear at reset; the memories
// need no clearing pass.
module client_level_vote_max_table_top #(
    parameter int MAX_CLIENTS = clvmt_pkg::MAX_CLIENTS_DEF,
    parameter int LEVEL_BITS  = clvmt_pkg::LEVEL_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // Fields from bit 0: command[2:0], client_id[18:3], level[34:19], zero pad.
    input  logic [clvmt_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // Fields from bit 0: ok[0], level_read[16:1], max_level[32:17],
    // entry_count[37:33], zero pad.
    output logic [clvmt_pkg::OUT_W-1:0]  m_axis_tdata
);

    clvmt_pkg::t_ctrl_cmd  ctrl_cmd;
    clvmt_pkg::t_dp_status dp_status;

    // The controller sequences capture, the table walk and the commit.
    clvmt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_status   (dp_status),
        .o_in_ready (s_axis_tready),
        .o_cmd      (ctrl_cmd)
    );

    // The datapath holds the table, the running maximum and the result register.
    clvmt_dp #(
        .MAX_CLIENTS (MAX_CLIENTS),
        .LEVEL_BITS  (LEVEL_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (ctrl_cmd),
        .o_status    (dp_status),
        .i_in_data   (s_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule

### sv/clvmt_checker.sv
// Port-level checker for the client level vote table, bound to the top level.
module clvmt_checker #(
    parameter int MAX_CLIENTS = clvmt_pkg::MAX_CLIENTS_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_s_tvalid,
    input logic                         i_s_tready,
    input logic [clvmt_pkg::IN_W-1:0]   i_s_tdata,
    input logic                         i_m_tvalid,
    input logic                         i_m_tready,
    input logic [clvmt_pkg::OUT_W-1:0]  i_m_tdata
);

    logic                          out_ok;
    logic [clvmt_pkg::LEVEL_W-1:0] out_rd;
    logic [clvmt_pkg::LEVEL_W-1:0] out_max;
    logic [clvmt_pkg::COUNT_W-1:0] out_cnt;
    logic [clvmt_pkg::CMD_W-1:0]   in_cmd;

    assign out_ok  = i_m_tdata[clvmt_pkg::OUT_OK_LO];
    assign out_rd  = i_m_tdata[clvmt_pkg::OUT_RD_LO +: clvmt_pkg::LEVEL_W];
    assign out_max = i_m_tdata[clvmt_pkg::OUT_MAX_LO +: clvmt_pkg::LEVEL_W];
    assign out_cnt = i_m_tdata[clvmt_pkg::OUT_CNT_LO +: clvmt_pkg::COUNT_W];
    assign in_cmd  = i_s_tdata[clvmt_pkg::IN_CMD_LO +: clvmt_pkg::CMD_W];

    // A stalled result beat must hold.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata))
        else $error("result beat changed while stalled");

    // The block works on one command at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && i_s_tready |=> !i_s_tready)
        else $error("second beat accepted while a command is in progress");

    // A failed command never reports a level.
    a_fail_no_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !out_ok |-> out_rd == '0)
        else $error("failed command reported a level");

    // An empty table has a zero maximum, and the count stays in range.
    a_empty_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> (MAX_CLIENTS >= 32)
            || ((out_cnt <= clvmt_pkg::COUNT_W'(MAX_CLIENTS))
                && (out_cnt != '0 || out_max == '0)))
        else $error("entry count or maximum inconsistent");

    // A clear always leaves an empty table. Its result is committed in the cycle
    // after acceptance when the output register has room at that point.
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && i_s_tready && in_cmd == clvmt_pkg::CMD_CLEAR
            ##1 (!i_m_tvalid || i_m_tready)
            |=> i_m_tvalid && out_ok && out_cnt == '0 && out_max == '0)
        else $error("clear did not empty the table");

endmodule

bind client_level_vote_max_table_top clvmt_checker #(
    .MAX_CLIENTS (MAX_CLIENTS)
) u_clvmt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_s_tdata  (s_axis_tdata),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata)
);
